>>> rtl/core/fast_approx_float_math_unit_macros.svh
// Assertion macros shared by the checker files of the approximate float unit.
// No dependencies; take in with `include before use.
`ifndef FAST_APPROX_FLOAT_MATH_UNIT_MACROS_SVH
`define FAST_APPROX_FLOAT_MATH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAFM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fafm: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define FAFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fafm: next-cycle property failed");

`endif

>>> rtl/core/fafm_pkg.sv
// Package of the approximate float unit: opcodes, float constants, item and
// micro-step types, the per-opcode step programme. No dependencies.
package fafm_pkg;

    localparam int NUM_STEPS = 10;

    // opcodes
    localparam logic [2:0] OP_RECIP = 3'd0;
    localparam logic [2:0] OP_RSQRT = 3'd1;
    localparam logic [2:0] OP_EXP2  = 3'd2;
    localparam logic [2:0] OP_LOG2  = 3'd3;
    localparam logic [2:0] OP_SIN   = 3'd4;
    localparam logic [2:0] OP_COS   = 3'd5;

    // micro-step kinds
    localparam logic [2:0] K_NOP    = 3'd0;
    localparam logic [2:0] K_ADD    = 3'd1;
    localparam logic [2:0] K_SUB    = 3'd2;
    localparam logic [2:0] K_MUL    = 3'd3;
    localparam logic [2:0] K_XSPLIT = 3'd4;

    // operand sources
    localparam logic [2:0] S_R0    = 3'd0;
    localparam logic [2:0] S_R1    = 3'd1;
    localparam logic [2:0] S_R2    = 3'd2;
    localparam logic [2:0] S_ABS0  = 3'd3;
    localparam logic [2:0] S_IMM   = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;

    // destinations
    localparam logic [1:0] D_R0 = 2'd0;
    localparam logic [1:0] D_R1 = 2'd1;
    localparam logic [1:0] D_R2 = 2'd2;

    localparam logic [31:0] MAGIC_RECIP   = 32'h7ef311c7;
    localparam logic [31:0] MAGIC_RSQRT   = 32'h5f375a86;
    localparam logic [31:0] MANT_MASK     = 32'h007fffff;
    localparam logic [31:0] ONE_BITS      = 32'h3f800000;
    localparam logic [31:0] QNAN_BITS     = 32'h7fc00000;
    localparam logic [31:0] PINF_BITS     = 32'h7f800000;
    localparam logic [31:0] DEFAULT_NAN   = 32'hffc00000;
    localparam logic [31:0] SIGN_BIT      = 32'h80000000;

    localparam logic [31:0] F_ONE         = 32'h3f800000;
    localparam logic [31:0] F_TWO         = 32'h40000000;
    localparam logic [31:0] F_HALF        = 32'h3f000000;
    localparam logic [31:0] F_THREE_HALF  = 32'h3fc00000;
    localparam logic [31:0] F_127         = 32'h42fe0000;
    localparam logic [31:0] F_EXP2_LO_MAG = 32'h42fc0000;
    localparam logic [31:0] F_EXP_C1      = 32'h3eadf5d0;
    localparam logic [31:0] F_EXP_C2      = 32'h3f290518;
    localparam logic [31:0] F_NEG_THIRD   = 32'hbeaaaaab;
    localparam logic [31:0] F_NEG_128     = 32'hc3000000;
    localparam logic [31:0] F_TWO_THIRDS  = 32'h3f2aaaab;
    localparam logic [31:0] F_NEG_INV_PI  = 32'hbea2f983;
    localparam logic [31:0] F_ROUND_MAGIC = 32'h4bc00000;
    localparam logic [31:0] F_SIN_A       = 32'h40656265;
    localparam logic [31:0] F_SIN_B       = 32'h4046a767;
    localparam logic [31:0] F_HALF_PI     = 32'h3fc90fdb;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  src_a;
        logic [2:0]  src_b;
        logic [1:0]  dst;
        logic [31:0] imm;
    } step_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [7:0]  scale_exp;
        logic        range_flag;
        logic        special;
        logic [31:0] special_bits;
    } item_t;

    function automatic step_t mk(input logic [2:0] kind, input logic [2:0] src_a,
                                 input logic [2:0] src_b, input logic [1:0] dst,
                                 input logic [31:0] imm);
        step_t s;
        s.kind  = kind;
        s.src_a = src_a;
        s.src_b = src_b;
        s.dst   = dst;
        s.imm   = imm;
        return s;
    endfunction

    function automatic step_t nop_step();
        return mk(K_NOP, S_R0, S_R0, D_R0, '0);
    endfunction

    function automatic step_t sin_prog(input logic [3:0] step);
        step_t s;
        case (step)
            4'd0:    s = mk(K_MUL, S_R0,   S_IMM, D_R0, F_NEG_INV_PI);
            4'd1:    s = mk(K_ADD, S_R0,   S_IMM, D_R1, F_ROUND_MAGIC);
            4'd2:    s = mk(K_SUB, S_R1,   S_IMM, D_R1, F_ROUND_MAGIC);
            4'd3:    s = mk(K_SUB, S_R0,   S_R1,  D_R0, '0);
            4'd4:    s = mk(K_SUB, S_ABS0, S_IMM, D_R1, F_ONE);
            4'd5:    s = mk(K_MUL, S_R0,   S_R1,  D_R0, '0);
            4'd6:    s = mk(K_MUL, S_IMM,  S_ABS0, D_R1, F_SIN_A);
            4'd7:    s = mk(K_ADD, S_R1,   S_IMM, D_R1, F_SIN_B);
            4'd8:    s = mk(K_MUL, S_R0,   S_R1,  D_R0, '0);
            default: s = nop_step();
        endcase
        return s;
    endfunction

    // Micro-step programme: the result always ends in r0.
    function automatic step_t prog(input logic [2:0] op, input logic [3:0] step);
        step_t s;
        s = nop_step();
        case (op)
            OP_RECIP:
                case (step)
                    4'd0:    s = mk(K_MUL, S_R0,  S_R1, D_R2, '0);
                    4'd1:    s = mk(K_SUB, S_IMM, S_R2, D_R2, F_TWO);
                    4'd2:    s = mk(K_MUL, S_R1,  S_R2, D_R0, '0);
                    default: s = nop_step();
                endcase
            OP_RSQRT:
                case (step)
                    4'd0:    s = mk(K_MUL, S_R0,  S_IMM, D_R0, F_HALF);
                    4'd1:    s = mk(K_MUL, S_R0,  S_R1,  D_R2, '0);
                    4'd2:    s = mk(K_MUL, S_R2,  S_R1,  D_R2, '0);
                    4'd3:    s = mk(K_SUB, S_IMM, S_R2,  D_R2, F_THREE_HALF);
                    4'd4:    s = mk(K_MUL, S_R1,  S_R2,  D_R0, '0);
                    default: s = nop_step();
                endcase
            OP_EXP2:
                case (step)
                    4'd0:    s = mk(K_ADD,    S_R0, S_IMM,   D_R1, F_127);
                    4'd1:    s = mk(K_XSPLIT, S_R1, S_R1,    D_R1, '0);
                    4'd2:    s = mk(K_ADD,    S_R0, S_R1,    D_R0, '0);
                    4'd3:    s = mk(K_MUL,    S_R0, S_IMM,   D_R1, F_EXP_C1);
                    4'd4:    s = mk(K_ADD,    S_R1, S_IMM,   D_R1, F_EXP_C2);
                    4'd5:    s = mk(K_MUL,    S_R0, S_R1,    D_R0, '0);
                    4'd6:    s = mk(K_ADD,    S_R0, S_IMM,   D_R0, F_ONE);
                    4'd7:    s = mk(K_MUL,    S_R0, S_SCALE, D_R0, '0);
                    default: s = nop_step();
                endcase
            OP_LOG2:
                case (step)
                    4'd0:    s = mk(K_MUL, S_R1,  S_IMM, D_R2, F_NEG_THIRD);
                    4'd1:    s = mk(K_ADD, S_R2,  S_IMM, D_R2, F_TWO);
                    4'd2:    s = mk(K_MUL, S_R1,  S_R2,  D_R2, '0);
                    4'd3:    s = mk(K_ADD, S_IMM, S_R2,  D_R2, F_NEG_128);
                    4'd4:    s = mk(K_SUB, S_R2,  S_IMM, D_R2, F_TWO_THIRDS);
                    4'd5:    s = mk(K_ADD, S_R0,  S_R2,  D_R0, '0);
                    default: s = nop_step();
                endcase
            OP_SIN:
                s = sin_prog(step);
            OP_COS:
                if (step == 4'd0)
                    s = mk(K_ADD, S_R0, S_IMM, D_R0, F_HALF_PI);
                else
                    s = sin_prog(4'(step - 4'd1));
            default:
                s = nop_step();
        endcase
        return s;
    endfunction

    // Exact conversion of a small signed integer (|v| <= 511) to single.
    function automatic logic [31:0] int_to_float(input logic sign, input logic [8:0] mag);
        logic [3:0]  p;
        logic [31:0] w;
        p = '0;
        for (int i = 0; i < 9; i++)
            if (mag[i])
                p = 4'(i);
        w = {23'b0, mag} << (5'd23 - {1'b0, p});
        if (mag == '0)
            return '0;
        return {sign, 8'(8'd127 + {4'b0, p}), w[22:0]};
    endfunction

endpackage

>>> rtl/core/fafm_alu.sv
// One micro-step of the approximate float unit: IEEE single add, subtract,
// multiply (round to nearest even), exp2 exponent split or no-op. Uses fafm_pkg.
module fafm_alu (
    input  fafm_pkg::item_t item_in,
    input  fafm_pkg::step_t step,
    output fafm_pkg::item_t item_out
);

    localparam logic [31:0] DEFAULT_NAN_L = fafm_pkg::DEFAULT_NAN;

    function automatic logic is_nan(input logic [31:0] x);
        return (&x[30:23]) && (|x[22:0]);
    endfunction

    function automatic logic [31:0] quiet(input logic [31:0] x);
        return x | 32'h00400000;
    endfunction

    // magn(): -0 and NaN keep their sign
    function automatic logic [31:0] magn(input logic [31:0] x);
        if (x[31] && !is_nan(x) && (x[30:0] != '0))
            return {1'b0, x[30:0]};
        return x;
    endfunction

    // value = mant / 2^26 * 2^(exp - 127); mant[26] leading unless zero
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [11:0] exp,
                                               input logic [26:0] mant);
        logic [26:0]        m;
        logic signed [11:0] e;
        logic [11:0]        sh;
        logic               inc;
        logic [24:0]        sig;
        logic [10:0]        ee;
        logic [33:0]        val;
        m = mant;
        e = exp;
        if (e < 12'sd1)
        begin
            sh = 12'(12'sd1 - e);
            if (sh >= 12'd27)
                m = {26'b0, |mant};
            else
                m = (mant >> sh) | {26'b0, |(mant & ((27'b1 << sh) - 27'b1))};
            e = 12'sd1;
        end
        inc = m[2] & (m[1] | m[0] | m[3]);
        sig = {1'b0, m[26:3]} + {24'b0, inc};
        ee  = 11'(e - 12'sd1);
        val = {ee, 23'b0} + {9'b0, sig};
        if (mant == '0)
            return {sign, 31'b0};
        if (val[33:23] >= 11'd255)
            return {sign, 8'hff, 23'b0};
        return {sign, val[30:0]};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic               sign;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        p;
        logic [47:0]        pn;
        logic [5:0]         lz;
        logic signed [11:0] e;
        logic               a_inf;
        logic               b_inf;
        logic               a_zero;
        logic               b_zero;
        sign   = a[31] ^ b[31];
        a_inf  = (a[30:23] == 8'hff);
        b_inf  = (b[30:23] == 8'hff);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        p  = ma * mb;
        lz = '0;
        for (int i = 0; i < 48; i++)
            if (p[i])
                lz = 6'(47 - i);
        pn = p << lz;
        e  = $signed(12'({4'b0, ea}) + 12'({4'b0, eb}) - 12'd126 - 12'({6'b0, lz}));
        if (is_nan(a))
            return quiet(a);
        if (is_nan(b))
            return quiet(b);
        if ((a_inf && b_zero) || (b_inf && a_zero))
            return DEFAULT_NAN_L;
        if (a_inf || b_inf)
            return {sign, 8'hff, 23'b0};
        if (a_zero || b_zero)
            return {sign, 31'b0};
        return round_pack(sign, e, {pn[47:22], |pn[21:0]});
    endfunction

    // a + b, or a - b when neg; NaN propagation takes b unflipped
    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b,
                                         input logic neg);
        logic [31:0]        bb;
        logic [31:0]        lg;
        logic [31:0]        sm;
        logic [7:0]         el;
        logic [7:0]         es;
        logic [7:0]         d;
        logic [26:0]        lx;
        logic [26:0]        sx;
        logic [26:0]        sxs;
        logic [27:0]        sum;
        logic [27:0]        n;
        logic [4:0]         lz;
        logic signed [11:0] e;
        logic               same;
        bb = b ^ {neg, 31'b0};
        if (a[30:0] >= bb[30:0])
        begin
            lg = a;
            sm = bb;
        end
        else
        begin
            lg = bb;
            sm = a;
        end
        el = (lg[30:23] == '0) ? 8'd1 : lg[30:23];
        es = (sm[30:23] == '0) ? 8'd1 : sm[30:23];
        d  = el - es;
        lx = {|lg[30:23], lg[22:0], 3'b0};
        sx = {|sm[30:23], sm[22:0], 3'b0};
        if (d >= 8'd27)
            sxs = {26'b0, |sx};
        else
            sxs = (sx >> d) | {26'b0, |(sx & ((27'b1 << d) - 27'b1))};
        same = (lg[31] == sm[31]);
        sum  = same ? ({1'b0, lx} + {1'b0, sxs}) : ({1'b0, lx} - {1'b0, sxs});
        lz = '0;
        for (int i = 0; i < 28; i++)
            if (sum[i])
                lz = 5'(27 - i);
        n = sum << lz;
        e = $signed(12'({4'b0, el}) + 12'd1 - 12'({7'b0, lz}));
        if (is_nan(a))
            return quiet(a);
        if (is_nan(b))
            return quiet(b);
        if ((a[30:23] == 8'hff) && (bb[30:23] == 8'hff) && (a[31] != bb[31]))
            return DEFAULT_NAN_L;
        if (a[30:23] == 8'hff)
            return a;
        if (bb[30:23] == 8'hff)
            return bb;
        if (sum == '0)
            return {same & lg[31], 31'b0};
        return round_pack(lg[31], e, {n[27:2], |n[1:0]});
    endfunction

    // exp2 split: e = trunc(t) for t in [1,254]
    function automatic logic [7:0] trunc_exp(input logic [31:0] t);
        logic [7:0]  k;
        logic [23:0] sig;
        logic [23:0] w;
        k   = t[30:23] - 8'd127;
        sig = {1'b1, t[22:0]};
        w   = sig >> (5'd23 - k[4:0]);
        if (t[31] || (t[30:23] < 8'd127) || (k > 8'd7))
            return '0;
        return w[7:0];
    endfunction

    logic [31:0]        opa;
    logic [31:0]        opb;
    logic [31:0]        res;
    logic [7:0]         e_split;
    logic signed [9:0]  bias_diff;
    logic [8:0]         bias_mag;

    function automatic logic [31:0] pick(input logic [2:0] src, input fafm_pkg::item_t it,
                                         input logic [31:0] imm);
        logic [31:0] v;
        case (src)
            fafm_pkg::S_R0:    v = it.r0;
            fafm_pkg::S_R1:    v = it.r1;
            fafm_pkg::S_R2:    v = it.r2;
            fafm_pkg::S_ABS0:  v = magn(it.r0);
            fafm_pkg::S_IMM:   v = imm;
            fafm_pkg::S_SCALE: v = {1'b0, it.scale_exp, 23'b0};
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa       = pick(step.src_a, item_in, step.imm);
        opb       = pick(step.src_b, item_in, step.imm);
        e_split   = trunc_exp(opa);
        bias_diff = 10'sd127 - $signed({2'b0, e_split});
        bias_mag  = bias_diff[9] ? 9'(-bias_diff) : bias_diff[8:0];
        item_out  = item_in;
        case (step.kind)
            fafm_pkg::K_ADD:    res = fadd(opa, opb, 1'b0);
            fafm_pkg::K_SUB:    res = fadd(opa, opb, 1'b1);
            fafm_pkg::K_MUL:    res = fmul(opa, opb);
            fafm_pkg::K_XSPLIT: res = fafm_pkg::int_to_float(bias_diff[9], bias_mag);
            default:            res = '0;
        endcase
        if (step.kind == fafm_pkg::K_XSPLIT)
            item_out.scale_exp = e_split;
        if (step.kind != fafm_pkg::K_NOP)
        begin
            case (step.dst)
                fafm_pkg::D_R0: item_out.r0 = res;
                fafm_pkg::D_R1: item_out.r1 = res;
                fafm_pkg::D_R2: item_out.r2 = res;
                default:        item_out.r0 = res;
            endcase
        end
    end

endmodule

>>> rtl/core/fast_approx_float_math_unit.sv
// Top level of the approximate single-precision math unit.
// Uses fafm_pkg and fafm_alu (one float micro-step per pipeline stage).
//
// Usage:
//   Input channel  operand_valid/operand_ready carries operation and
//   operand_bits; output channel result_valid/result_ready carries
//   result_bits and range_flag. An item moves when valid and ready are both
//   high at a rising edge of clk.
//   Operations: 0 recip, 1 rsqrt, 2 exp2, 3 log2, 4 sin, 5 cos; codes 6 and
//   7 give zero with the flag clear.
//   Pipeline: an entry register, then ten stages each applying one micro-step
//   (a float add, subtract or multiply, the exp2 split or nothing).
//   Throughput: one item per cycle while result_ready is high; set by
//   the single float unit in each stage, which every item passes through once.
//   Stalls: each stage holds its item only while the one after it is full
//   and also held, so bubbles close up and operand_ready stays high while
//   any stage is free. A stalled result holds steady until taken.
//   Reset (rst_n low, asynchronous) empties the pipeline; no item is lost
//   or repeated across a stall.
module fast_approx_float_math_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        operand_valid,
    output logic        operand_ready,
    input  logic [2:0]  operation,
    input  logic [31:0] operand_bits,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] result_bits,
    output logic        range_flag
);

    localparam int NUM_REGS = fafm_pkg::NUM_STEPS + 1;

    fafm_pkg::item_t stage_reg  [NUM_REGS];
    fafm_pkg::item_t stage_next [NUM_REGS];
    logic            valid_reg  [NUM_REGS];
    logic            valid_next [NUM_REGS];
    logic            stage_ready[NUM_REGS];
    logic            valid_in   [NUM_REGS];

    // entry stage decode
    fafm_pkg::item_t prep;
    logic            x_nan;
    logic            x_above;
    logic            x_below;

    always_comb
    begin
        x_nan   = (&operand_bits[30:23]) && (|operand_bits[22:0]);
        x_above = !operand_bits[31] && (operand_bits > fafm_pkg::F_127);
        x_below = operand_bits[31] && (operand_bits[30:0] > fafm_pkg::F_EXP2_LO_MAG[30:0]);

        prep.operation    = operation;
        prep.r0           = operand_bits;
        prep.r1           = '0;
        prep.r2           = '0;
        prep.scale_exp    = '0;
        prep.range_flag   = 1'b0;
        prep.special      = 1'b0;
        prep.special_bits = '0;
        case (operation)
            fafm_pkg::OP_RECIP:
                prep.r1 = fafm_pkg::MAGIC_RECIP - operand_bits;
            fafm_pkg::OP_RSQRT:
                prep.r1 = fafm_pkg::MAGIC_RSQRT
                        - ((operand_bits >> 1) | (operand_bits & fafm_pkg::SIGN_BIT));
            fafm_pkg::OP_EXP2:
            begin
                // out-of-range and NaN operands bypass the arithmetic
                prep.range_flag = x_nan || x_above || x_below;
                prep.special    = x_nan || x_above || x_below;
                prep.special_bits = x_nan   ? fafm_pkg::QNAN_BITS :
                                    x_above ? fafm_pkg::PINF_BITS : '0;
            end
            fafm_pkg::OP_LOG2:
            begin
                // sign bit joins the exponent as a 9-bit signed value
                prep.r0 = fafm_pkg::int_to_float(operand_bits[31],
                              operand_bits[31] ? 9'(9'd256 - {1'b0, operand_bits[30:23]})
                                               : {1'b0, operand_bits[30:23]});
                prep.r1 = fafm_pkg::ONE_BITS | (operand_bits & fafm_pkg::MANT_MASK);
                prep.range_flag = !(!operand_bits[31] && !x_nan && (operand_bits[30:0] != '0));
            end
            fafm_pkg::OP_SIN,
            fafm_pkg::OP_COS:
                prep.special = 1'b0;
            default:
                prep.special = 1'b1;
        endcase
    end

    // ready ripples back from the output; a stage takes a new item when
    // empty or when its own item moves on
    assign stage_ready[NUM_REGS-1] = !valid_reg[NUM_REGS-1] || result_ready;

    genvar g;
    generate
        for (g = 0; g < NUM_REGS - 1; g++)
        begin : g_ready
            assign stage_ready[g] = !valid_reg[g] || stage_ready[g+1];
        end

        for (g = 0; g < fafm_pkg::NUM_STEPS; g++)
        begin : g_step
            fafm_alu u_alu (
                .item_in  (stage_reg[g]),
                .step     (fafm_pkg::prog(stage_reg[g].operation, 4'(g))),
                .item_out (stage_next[g+1])
            );
            assign valid_in[g+1] = valid_reg[g];
        end
    endgenerate

    assign stage_next[0] = prep;
    assign valid_in[0]   = operand_valid;

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
            valid_next[i] = stage_ready[i] ? valid_in[i] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
                valid_reg[i] <= valid_next[i];
        end
    end

    // payload carries no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_REGS; i++)
            if (stage_ready[i] && valid_in[i])
                stage_reg[i] <= stage_next[i];
    end

    assign operand_ready = stage_ready[0];
    assign result_valid  = valid_reg[NUM_REGS-1];
    assign result_bits   = stage_reg[NUM_REGS-1].special ? stage_reg[NUM_REGS-1].special_bits
                                                         : stage_reg[NUM_REGS-1].r0;
    assign range_flag    = stage_reg[NUM_REGS-1].range_flag;

endmodule

>>> rtl/core/fafm_props.sv
// Port-level checks for the approximate float unit, bound to its top level.
// Depends on fast_approx_float_math_unit_macros.svh.
`include "fast_approx_float_math_unit_macros.svh"

module fafm_props (
    input logic        clk,
    input logic        rst_n,
    input logic        operand_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] result_bits,
    input logic        range_flag
);

    // a stalled result stays put
    `FAFM_ASSERT_NEXT(a_out_hold, clk, rst_n, result_valid && !result_ready, result_valid)
    `FAFM_ASSERT_NEXT(a_bits_stable, clk, rst_n, result_valid && !result_ready, $stable(result_bits))
    `FAFM_ASSERT_NEXT(a_flag_stable, clk, rst_n, result_valid && !result_ready, $stable(range_flag))

    // bubbles close up: a draining output never blocks the input
    `FAFM_ASSERT_IMPLY(a_ready_flow, clk, rst_n, result_ready, operand_ready)

    // pipeline comes out of reset empty
    `FAFM_ASSERT_IMPLY(a_reset_empty, clk, rst_n, $past(!rst_n), !result_valid)

endmodule

bind fast_approx_float_math_unit fafm_props u_fafm_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_ready (operand_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_bits   (result_bits),
    .range_flag    (range_flag)
);
